@@ rtl/bmpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpe_pkg - shared types and constants of the binomial engine
// Table geometry, datapath widths, register indexes and builder interfaces.
// ----------------------------------------------------------------------------
package bmpe_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int VAL_W       = 31;
	localparam int TOP_W       = 12;
	localparam int ARG_W       = 16;
	localparam int PROD_W      = 2 * VAL_W;
	// one product stage, then one conditional subtract per product bit
	localparam int MUL_LAT     = 1 + PROD_W;
	localparam int LAT_W       = $clog2(MUL_LAT + 1);
	localparam int BIT_W       = $clog2(VAL_W);

	localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd998244353;
	localparam logic [TOP_W-1:0] TOP_RESET     = 12'd4095;

	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_MODULUS   = 2'd0;
	localparam logic [IDX_W-1:0] REG_TOP_INDEX = 2'd1;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              fact_we;
		logic              inv_we;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  data;
	} tbl_wr_t;

endpackage

@@ rtl/bmpe_modmul.sv @@
// ----------------------------------------------------------------------------
// bmpe_modmul - pipelined modular multiplier
// Registered 31x31 product, then restoring reduction, one bit per stage.
// ----------------------------------------------------------------------------
module bmpe_modmul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [bmpe_pkg::VAL_W-1:0] a,
	input  logic [bmpe_pkg::VAL_W-1:0] b,
	input  logic [bmpe_pkg::VAL_W-1:0] m,
	output logic                       out_valid,
	output logic [bmpe_pkg::VAL_W-1:0] p
);

	localparam int PW = bmpe_pkg::PROD_W;

	logic [PW-1:0] red_q [0:PW];
	logic          vld_q [0:PW];
	logic [PW-1:0] m_ext;

	assign m_ext = {{(PW - bmpe_pkg::VAL_W){1'b0}}, m};

	always_ff @(posedge clk) begin
		if (en) red_q[0] <= PW'(a) * PW'(b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q[0] <= 1'b0;
		else if (en) vld_q[0] <= in_valid;
	end

	for (genvar j = 0; j < PW; j++) begin : g_red
		localparam int K = PW - 1 - j;
		logic [PW-1:0] hi;
		logic          ge;
		// residue lies below m*2^(K+1); drop m*2^K when it fits
		assign hi = red_q[j] >> K;
		assign ge = (hi >= m_ext);

		always_ff @(posedge clk) begin
			if (en) red_q[j+1] <= ge ? (red_q[j] - (m_ext << K)) : red_q[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[j+1] <= 1'b0;
			else if (en) vld_q[j+1] <= vld_q[j];
		end
	end

	assign out_valid = vld_q[PW];
	assign p         = red_q[PW][bmpe_pkg::VAL_W-1:0];

endmodule

@@ rtl/bmpe_tables.sv @@
// ----------------------------------------------------------------------------
// bmpe_tables - factorial and inverse factorial memories
// One write port each; one read port on factorials, two on inverses.
// ----------------------------------------------------------------------------
module bmpe_tables (
	input  logic                        clk,
	input  bmpe_pkg::tbl_wr_t           wr,
	input  logic                        rd_en,
	input  logic [bmpe_pkg::ADDR_W-1:0] fact_addr,
	input  logic [bmpe_pkg::ADDR_W-1:0] inv_addr_a,
	input  logic [bmpe_pkg::ADDR_W-1:0] inv_addr_b,
	output logic [bmpe_pkg::VAL_W-1:0]  fact_data,
	output logic [bmpe_pkg::VAL_W-1:0]  inv_data_a,
	output logic [bmpe_pkg::VAL_W-1:0]  inv_data_b
);

	logic [bmpe_pkg::VAL_W-1:0] fact_mem [0:bmpe_pkg::TABLE_DEPTH-1];
	logic [bmpe_pkg::VAL_W-1:0] inv_mem  [0:bmpe_pkg::TABLE_DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr.fact_we) fact_mem[wr.addr] <= wr.data;
		if (rd_en) fact_data <= fact_mem[fact_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.inv_we) inv_mem[wr.addr] <= wr.data;
		if (rd_en) begin
			inv_data_a <= inv_mem[inv_addr_a];
			inv_data_b <= inv_mem[inv_addr_b];
		end
	end

endmodule

@@ rtl/bmpe_builder.sv @@
// ----------------------------------------------------------------------------
// bmpe_builder - table build sequencer
// Fills factorials upward, takes the top inverse by square and multiply,
// then fills inverse factorials downward, one multiply at a time.
// ----------------------------------------------------------------------------
module bmpe_builder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       adv,
	input  logic [bmpe_pkg::VAL_W-1:0] m_eff,
	input  logic [bmpe_pkg::TOP_W-1:0] top_eff,
	input  logic                       res_valid,
	input  logic [bmpe_pkg::VAL_W-1:0] res,
	output bmpe_pkg::mul_req_t         req,
	output bmpe_pkg::tbl_wr_t          wr,
	output logic                       ready
);

	typedef enum logic [6:0] {
		ST_FLUSH = 7'b0000001,
		ST_FACT  = 7'b0000010,
		ST_SQR   = 7'b0000100,
		ST_MULB  = 7'b0001000,
		ST_TOPW  = 7'b0010000,
		ST_INV   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                           state_q;
	logic [bmpe_pkg::LAT_W-1:0]       flush_q;
	logic [bmpe_pkg::TOP_W-1:0]       i_q;
	logic [bmpe_pkg::VAL_W-1:0]       acc_q;
	logic [bmpe_pkg::VAL_W-1:0]       base_q;
	logic [bmpe_pkg::VAL_W-1:0]       exp_q;
	logic [bmpe_pkg::BIT_W-1:0]       bit_q;
	logic                             wait_q;
	bmpe_pkg::tbl_wr_t                wr_q;
	logic [bmpe_pkg::VAL_W-1:0]       one;
	logic                             busy_mul;
	logic                             take;
	logic [bmpe_pkg::VAL_W-1:0]       i_ext;

	assign one      = (m_eff == bmpe_pkg::VAL_W'(1)) ? '0 : bmpe_pkg::VAL_W'(1);
	assign busy_mul = (state_q inside {ST_FACT, ST_SQR, ST_MULB, ST_INV});
	assign take     = busy_mul && wait_q && res_valid && adv;
	assign i_ext    = bmpe_pkg::VAL_W'(i_q);

	always_comb begin
		req.valid = busy_mul && !wait_q && adv;
		req.a     = acc_q;
		case (state_q)
			ST_FACT, ST_INV: req.b = i_ext;
			ST_SQR:          req.b = acc_q;
			ST_MULB:         req.b = base_q;
			default:         req.b = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FLUSH;
			flush_q    <= bmpe_pkg::LAT_W'(bmpe_pkg::MUL_LAT);
			wait_q     <= 1'b0;
			wr_q.fact_we <= 1'b0;
			wr_q.inv_we  <= 1'b0;
		end else begin
			wr_q.fact_we <= 1'b0;
			wr_q.inv_we  <= 1'b0;
			if (start) begin
				// restart: let any product in flight drain first
				state_q <= ST_FLUSH;
				flush_q <= bmpe_pkg::LAT_W'(bmpe_pkg::MUL_LAT);
				wait_q  <= 1'b0;
			end else begin
				if (req.valid) wait_q <= 1'b1;
				if (take) wait_q <= 1'b0;
				case (state_q)
					ST_FLUSH: begin
						if (adv) begin
							if (flush_q != '0) begin
								flush_q <= flush_q - 1'b1;
							end else begin
								wr_q.fact_we <= 1'b1;
								wr_q.addr    <= '0;
								wr_q.data    <= one;
								acc_q        <= one;
								i_q          <= bmpe_pkg::TOP_W'(1);
								if (top_eff == '0) begin
									base_q  <= one;
									exp_q   <= '0;
									bit_q   <= bmpe_pkg::BIT_W'(bmpe_pkg::VAL_W - 1);
									state_q <= ST_SQR;
								end else begin
									state_q <= ST_FACT;
								end
							end
						end
					end
					ST_FACT: begin
						if (take) begin
							wr_q.fact_we <= 1'b1;
							wr_q.addr    <= bmpe_pkg::ADDR_W'(i_q);
							wr_q.data    <= res;
							if (i_q == top_eff) begin
								// start Fermat power of the top factorial
								base_q  <= res;
								acc_q   <= one;
								exp_q   <= (m_eff >= bmpe_pkg::VAL_W'(2)) ?
									(m_eff - bmpe_pkg::VAL_W'(2)) : '0;
								bit_q   <= bmpe_pkg::BIT_W'(bmpe_pkg::VAL_W - 1);
								state_q <= ST_SQR;
							end else begin
								acc_q <= res;
								i_q   <= i_q + 1'b1;
							end
						end
					end
					ST_SQR: begin
						if (take) begin
							acc_q <= res;
							if (exp_q[bit_q]) state_q <= ST_MULB;
							else if (bit_q == '0) state_q <= ST_TOPW;
							else bit_q <= bit_q - 1'b1;
						end
					end
					ST_MULB: begin
						if (take) begin
							acc_q <= res;
							if (bit_q == '0) begin
								state_q <= ST_TOPW;
							end else begin
								bit_q   <= bit_q - 1'b1;
								state_q <= ST_SQR;
							end
						end
					end
					ST_TOPW: begin
						wr_q.inv_we <= 1'b1;
						wr_q.addr   <= bmpe_pkg::ADDR_W'(top_eff);
						wr_q.data   <= acc_q;
						i_q         <= top_eff;
						state_q     <= (top_eff == '0) ? ST_DONE : ST_INV;
					end
					ST_INV: begin
						if (take) begin
							wr_q.inv_we <= 1'b1;
							wr_q.addr   <= bmpe_pkg::ADDR_W'(i_q - 1'b1);
							wr_q.data   <= res;
							acc_q       <= res;
							if (i_q == bmpe_pkg::TOP_W'(1)) state_q <= ST_DONE;
							else i_q <= i_q - 1'b1;
						end
					end
					ST_DONE: begin
						state_q <= ST_DONE;
					end
					default: begin
						state_q <= ST_FLUSH;
						flush_q <= bmpe_pkg::LAT_W'(bmpe_pkg::MUL_LAT);
					end
				endcase
			end
		end
	end

	assign wr    = wr_q;
	// hold ready until the last table write has landed in memory
	assign ready = (state_q == ST_DONE) && !wr_q.inv_we && !start;

endmodule

@@ rtl/binomial_mod_prime_engine.sv @@
// ----------------------------------------------------------------------------
// binomial_mod_prime_engine - C(n,r) modulo a configured prime
// Table lookups of n!, 1/r! and 1/(n-r)! feed two pipelined modular
// multipliers; a build sequencer fills the tables after reset and writes.
// ----------------------------------------------------------------------------
// Pipeline: table read, two 63-stage modular multipliers, output register;
//   one request per cycle sustained unless the build or out_stall holds the flow.
// Build: after reset and after every write to the modulus or top index
//   register the tables are rebuilt through one shared multiplier, which
//   takes one multiply at a time, each waiting for the product before it.
// Requests are stalled throughout the build; register writes are taken.
// ----------------------------------------------------------------------------
module binomial_mod_prime_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	// query request channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [15:0]         n_value,
	input  logic signed [15:0]         r_value,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [30:0]                coefficient,
	output logic                       out_of_range,
	// configuration writes
	input  logic                       cfg_we,
	input  logic [bmpe_pkg::IDX_W-1:0] cfg_index,
	input  logic [30:0]                cfg_wdata
);

	localparam int VW = bmpe_pkg::VAL_W;
	localparam int AW = bmpe_pkg::ADDR_W;
	localparam int LAT = bmpe_pkg::MUL_LAT;
	localparam logic [bmpe_pkg::TOP_W-1:0] TOP_MAX =
		bmpe_pkg::TOP_W'(bmpe_pkg::TABLE_DEPTH - 1);

	// configuration registers
	logic [VW-1:0]               modulus_q;
	logic [bmpe_pkg::TOP_W-1:0]  top_q;
	logic [VW-1:0]               m_eff;
	logic [bmpe_pkg::TOP_W-1:0]  top_eff;
	logic                        cfg_hit;

	// pipeline control
	logic adv;
	logic accept;
	logic ready;

	// request decode
	logic          arg_ok;
	logic          n_over;
	logic [15:0]   nr_diff;

	// stage 2: table data and flags
	logic          valid_s2;
	logic          use_s2;
	logic          oor_s2;
	logic [VW-1:0] fact_rd;
	logic [VW-1:0] inv_r_rd;
	logic [VW-1:0] inv_nr_rd;

	// builder links
	bmpe_pkg::mul_req_t b_req;
	bmpe_pkg::tbl_wr_t  b_wr;

	// multiplier links
	logic          mula_vin;
	logic [VW-1:0] mula_a;
	logic [VW-1:0] mula_b;
	logic          mula_vout;
	logic [VW-1:0] mula_p;
	logic          mulb_vout;
	logic [VW-1:0] mulb_p;

	// side band alongside the multipliers
	logic [VW+1:0] dly_a_q [0:LAT-1];
	logic [1:0]    dly_b_q [0:LAT-1];

	// output register
	logic          out_valid_q;
	logic [VW-1:0] coef_q;
	logic          oor_q;

	// ---------------------------------------------------------------------
	// Configuration: a write to a known register restarts the build
	// ---------------------------------------------------------------------
	assign cfg_hit = cfg_we && (cfg_index == bmpe_pkg::REG_MODULUS ||
		cfg_index == bmpe_pkg::REG_TOP_INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= bmpe_pkg::MODULUS_RESET;
			top_q     <= bmpe_pkg::TOP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bmpe_pkg::REG_MODULUS:   modulus_q <= cfg_wdata;
				bmpe_pkg::REG_TOP_INDEX: top_q     <= cfg_wdata[bmpe_pkg::TOP_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero modulus behaves as one; clamp the top to the last table entry
	assign m_eff   = (modulus_q == '0) ? VW'(1) : modulus_q;
	assign top_eff = (top_q > TOP_MAX) ? TOP_MAX : top_q;

	// ---------------------------------------------------------------------
	// Flow control: the whole pipeline holds while a result waits
	// ---------------------------------------------------------------------
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !ready || !adv;
	assign accept   = in_valid && !in_stall;

	// ---------------------------------------------------------------------
	// Request decode: negative arguments or r above n give zero, and a
	// valid n past the top gives zero with the range flag
	// ---------------------------------------------------------------------
	assign arg_ok  = !n_value[15] && !r_value[15] && (r_value <= n_value);
	assign n_over  = (n_value[14:0] > 15'(top_eff));
	assign nr_diff = n_value - r_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (adv) valid_s2 <= accept;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			use_s2 <= arg_ok && !n_over;
			oor_s2 <= arg_ok && n_over;
		end
	end

	bmpe_tables u_tables (
		.clk        (clk),
		.wr         (b_wr),
		.rd_en      (adv),
		.fact_addr  (n_value[AW-1:0]),
		.inv_addr_a (r_value[AW-1:0]),
		.inv_addr_b (nr_diff[AW-1:0]),
		.fact_data  (fact_rd),
		.inv_data_a (inv_r_rd),
		.inv_data_b (inv_nr_rd)
	);

	bmpe_builder u_builder (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cfg_hit),
		.adv       (adv),
		.m_eff     (m_eff),
		.top_eff   (top_eff),
		.res_valid (mula_vout),
		.res       (mula_p),
		.req       (b_req),
		.wr        (b_wr),
		.ready     (ready)
	);

	// ---------------------------------------------------------------------
	// First multiplier: shared by the builder while tables are not ready
	// ---------------------------------------------------------------------
	assign mula_vin = ready ? valid_s2 : b_req.valid;
	assign mula_a   = ready ? fact_rd  : b_req.a;
	assign mula_b   = ready ? inv_r_rd : b_req.b;

	bmpe_modmul u_mul_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (mula_vin),
		.a         (mula_a),
		.b         (mula_b),
		.m         (m_eff),
		.out_valid (mula_vout),
		.p         (mula_p)
	);

	// carry 1/(n-r)! and the flags in step with the first product
	always_ff @(posedge clk) begin
		if (adv) begin
			dly_a_q[0] <= {use_s2, oor_s2, inv_nr_rd};
			for (int k = 1; k < LAT; k++) dly_a_q[k] <= dly_a_q[k-1];
		end
	end

	// ---------------------------------------------------------------------
	// Second multiplier: query traffic only
	// ---------------------------------------------------------------------
	bmpe_modmul u_mul_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (mula_vout && ready),
		.a         (mula_p),
		.b         (dly_a_q[LAT-1][VW-1:0]),
		.m         (m_eff),
		.out_valid (mulb_vout),
		.p         (mulb_p)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			dly_b_q[0] <= dly_a_q[LAT-1][VW+1:VW];
			for (int k = 1; k < LAT; k++) dly_b_q[k] <= dly_b_q[k-1];
		end
	end

	// ---------------------------------------------------------------------
	// Output register: zero the coefficient unless the query was valid and in range
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= mulb_vout;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_q <= dly_b_q[LAT-1][1] ? mulb_p : '0;
			oor_q  <= dly_b_q[LAT-1][0];
		end
	end

	assign out_valid    = out_valid_q;
	assign coefficient  = coef_q;
	assign out_of_range = oor_q;

endmodule

@@ tb/tb_binomial_mod_prime_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_mod_prime_engine - self-checking bench for the binomial engine
// Drives C(n,r) requests through a short table of corner cases, then random
// requests under several modulus and table-top settings. Every result is
// compared against a fixed expected value or an in-bench factorial table predictor.
// ----------------------------------------------------------------------------
module tb_binomial_mod_prime_engine;

	// unused register slots: writes there must leave the tables alone
	localparam logic [bmpe_pkg::IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [bmpe_pkg::IDX_W-1:0] REG_SPARE_3 = 2'd3;
	// allow several times the total run length, reset build included
	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 140;

	typedef struct {
		logic [bmpe_pkg::VAL_W-1:0] coef;
		bit                         oor;
	} binom_res_t;

	typedef struct {
		bit                         known;
		logic [bmpe_pkg::VAL_W-1:0] coef;
		bit                         oor;
	} typed_exp_t;

	typedef struct {
		logic signed [bmpe_pkg::ARG_W-1:0] n;
		logic signed [bmpe_pkg::ARG_W-1:0] r;
		bit                                known;
		logic [bmpe_pkg::VAL_W-1:0]        coef;
		bit                                oor;
	} corner_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic signed [bmpe_pkg::ARG_W-1:0] n_value = '0;
	logic signed [bmpe_pkg::ARG_W-1:0] r_value = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [bmpe_pkg::VAL_W-1:0]        coefficient;
	logic                              out_of_range;
	logic                              cfg_we = 1'b0;
	logic [bmpe_pkg::IDX_W-1:0]        cfg_index = '0;
	logic [bmpe_pkg::VAL_W-1:0]        cfg_wdata = '0;

	binomial_mod_prime_engine i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.n_value      (n_value),
		.r_value      (r_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.coefficient  (coefficient),
		.out_of_range (out_of_range),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: own copy of the registers and both tables
	// ------------------------------------------------------------------
	logic [bmpe_pkg::VAL_W-1:0] mdl_modulus = bmpe_pkg::MODULUS_RESET;
	logic [bmpe_pkg::TOP_W-1:0] mdl_top     = bmpe_pkg::TOP_RESET;
	logic [63:0]                fact_tbl     [bmpe_pkg::TABLE_DEPTH];
	logic [63:0]                inv_fact_tbl [bmpe_pkg::TABLE_DEPTH];

	function automatic logic [63:0] live_modulus();
		return (mdl_modulus == '0) ? 64'd1 : 64'(mdl_modulus);
	endfunction

	function automatic int live_top();
		return (int'(mdl_top) > bmpe_pkg::TABLE_DEPTH - 1) ?
			bmpe_pkg::TABLE_DEPTH - 1 : int'(mdl_top);
	endfunction

	// square and multiply over all 64 exponent bits, top bit first
	function automatic logic [63:0] fermat_pow(logic [63:0] base, logic [63:0] e,
			logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1;
		for (int b = 63; b >= 0; b--) begin
			acc = (acc * acc) % m;
			if (e[b])
				acc = (acc * base) % m;
		end
		return acc;
	endfunction

	function automatic void rebuild_tables();
		logic [63:0] m;
		int          top;
		m   = live_modulus();
		top = live_top();
		for (int i = 0; i < bmpe_pkg::TABLE_DEPTH; i++) begin
			fact_tbl[i]     = '0;
			inv_fact_tbl[i] = '0;
		end
		fact_tbl[0] = 64'd1 % m;
		for (int i = 1; i <= top; i++)
			fact_tbl[i] = (fact_tbl[i-1] * 64'(i)) % m;
		inv_fact_tbl[top] = fermat_pow(fact_tbl[top], (m >= 2) ? m - 2 : 64'd0, m);
		for (int i = top; i > 0; i--)
			inv_fact_tbl[i-1] = (inv_fact_tbl[i] * 64'(i)) % m;
	endfunction

	function automatic binom_res_t binom_predict(logic signed [bmpe_pkg::ARG_W-1:0] n,
			logic signed [bmpe_pkg::ARG_W-1:0] r);
		binom_res_t  res;
		logic [63:0] m;
		logic [63:0] acc;
		m        = live_modulus();
		res.coef = '0;
		res.oor  = 1'b0;
		// invalid arguments win over the range test
		if (r > n || r < 0 || n < 0) begin
			res.coef = '0;
		end else if (int'(n) > live_top()) begin
			res.oor = 1'b1;
		end else begin
			acc      = fact_tbl[int'(n)];
			acc      = (acc * inv_fact_tbl[int'(r)]) % m;
			acc      = (acc * inv_fact_tbl[int'(n - r)]) % m;
			res.coef = acc[bmpe_pkg::VAL_W-1:0];
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request monitor and result checker
	// ------------------------------------------------------------------
	typed_exp_t typed_q [$];   // one entry per request queued by the driver
	binom_res_t coef_due_q [$];
	int         errors = 0;

	always @(posedge clk) begin
		typed_exp_t t;
		binom_res_t p;
		binom_res_t want;
		if (in_valid && !in_stall) begin
			t = typed_q.pop_front();
			p = binom_predict(n_value, r_value);
			if (t.known) begin
				want.coef = t.coef;
				want.oor  = t.oor;
			end else begin
				want = p;
			end
			coef_due_q.push_back(want);
		end
		if (out_valid && !out_stall) begin
			if (coef_due_q.size() == 0) begin
				$error("unexpected result coefficient=%0d out_of_range=%0d",
					coefficient, out_of_range);
				errors++;
			end else begin
				want = coef_due_q.pop_front();
				if (coefficient !== want.coef) begin
					$error("coefficient expected %0d actual %0d", want.coef, coefficient);
					errors++;
				end
				if (out_of_range !== want.oor) begin
					$error("out_of_range expected %0d actual %0d", want.oor, out_of_range);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern changes mode every so often
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				out_stall <= ($urandom_range(0, 7) != 0);
			end
			default: begin
				out_stall <= ($urandom_range(0, 1) == 0);
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_binomial_mod_prime_engine NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender: requests go out in bursts; the driver always rests on a
	// rising edge between calls
	// ------------------------------------------------------------------
	bit drv_high   = 1'b0;
	int burst_left = 0;

	task automatic send_query(logic signed [bmpe_pkg::ARG_W-1:0] n,
			logic signed [bmpe_pkg::ARG_W-1:0] r,
			bit known, logic [bmpe_pkg::VAL_W-1:0] coef, bit oor);
		typed_exp_t t;
		int         gap;
		t.known = known;
		t.coef  = coef;
		t.oor   = oor;
		typed_q.push_back(t);
		in_valid <= 1'b1;
		n_value  <= n;
		r_value  <= r;
		drv_high = 1'b1;
		// hold the request until the engine takes it
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			drv_high = 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
				: $urandom_range(0, 20);
		end
	endtask

	// drop valid and wait until every result is back, then let the pipe settle
	task automatic drain_results();
		if (drv_high) begin
			in_valid <= 1'b0;
			drv_high = 1'b0;
		end
		while (coef_due_q.size() != 0 || typed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [bmpe_pkg::IDX_W-1:0] idx,
			logic [bmpe_pkg::VAL_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bmpe_pkg::REG_MODULUS) begin
			mdl_modulus = data;
			rebuild_tables();
		end else if (idx == bmpe_pkg::REG_TOP_INDEX) begin
			mdl_top = data[bmpe_pkg::TOP_W-1:0];
			rebuild_tables();
		end
	endtask

	// mostly well-formed queries inside the table, the rest out of range,
	// invalid or raw noise
	task automatic send_random(int count, bit pause_midway);
		int                                top;
		int                                pick;
		logic signed [bmpe_pkg::ARG_W-1:0] n;
		logic signed [bmpe_pkg::ARG_W-1:0] r;
		top = live_top();
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				n = bmpe_pkg::ARG_W'($urandom_range(0, top));
				r = bmpe_pkg::ARG_W'($urandom_range(0, int'(n)));
			end else if (pick == 7) begin
				n = bmpe_pkg::ARG_W'($urandom_range(top + 1, 32767));
				r = bmpe_pkg::ARG_W'($urandom_range(0, 65535));
			end else if (pick == 8) begin
				n = bmpe_pkg::ARG_W'($urandom_range(0, top));
				r = ($urandom_range(0, 1) == 0) ?
					bmpe_pkg::ARG_W'($urandom_range(32768, 65535))
					: n + bmpe_pkg::ARG_W'($urandom_range(1, 100));
			end else begin
				n = bmpe_pkg::ARG_W'($urandom());
				r = bmpe_pkg::ARG_W'($urandom());
			end
			send_query(n, r, 1'b0, '0, 1'b0);
			if (pause_midway && i == count / 2)
				drain_results();
		end
	endtask

	// corners of the current setting: C(0,0), C(top,top), C(top,0), just past top
	task automatic send_setting_corners();
		int top;
		top = live_top();
		send_query(16'sd0, 16'sd0, 1'b0, '0, 1'b0);
		send_query(bmpe_pkg::ARG_W'(top), bmpe_pkg::ARG_W'(top), 1'b0, '0, 1'b0);
		send_query(bmpe_pkg::ARG_W'(top), 16'sd0, 1'b0, '0, 1'b0);
		send_query(bmpe_pkg::ARG_W'(top + 1), 16'sd0, 1'b1, '0, 1'b1);
	endtask

	// reset setting: modulus 998244353, top 4095
	corner_row_t corner_tab [18] = '{
		'{16'sd0,      16'sd0,      1'b1, 31'd1,    1'b0},
		'{16'sd1,      16'sd1,      1'b1, 31'd1,    1'b0},
		'{16'sd4095,   16'sd0,      1'b1, 31'd1,    1'b0},
		'{16'sd4095,   16'sd4095,   1'b1, 31'd1,    1'b0},
		'{16'sd4095,   16'sd1,      1'b1, 31'd4095, 1'b0},
		'{16'sd10,     16'sd3,      1'b0, 31'd0,    1'b0},
		'{16'sd4095,   16'sd2047,   1'b0, 31'd0,    1'b0},
		'{16'sd100,    16'sd50,     1'b0, 31'd0,    1'b0},
		// n beyond the table top
		'{16'sd4096,   16'sd0,      1'b1, 31'd0,    1'b1},
		'{16'sd32767,  16'sd0,      1'b1, 31'd0,    1'b1},
		'{16'sd32767,  16'sd32767,  1'b1, 31'd0,    1'b1},
		// invalid arguments, checked ahead of the range test
		'{-16'sd1,     16'sd0,      1'b1, 31'd0,    1'b0},
		'{-16'sd1,     -16'sd1,     1'b1, 31'd0,    1'b0},
		'{16'sd5,      16'sd6,      1'b1, 31'd0,    1'b0},
		'{16'sd5,      -16'sd1,     1'b1, 31'd0,    1'b0},
		'{-16'sd32768, -16'sd32768, 1'b1, 31'd0,    1'b0},
		'{16'sd32767,  -16'sd32768, 1'b1, 31'd0,    1'b0},
		'{-16'sd32768, 16'sd32767,  1'b1, 31'd0,    1'b0}
	};

	initial begin
		rebuild_tables();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: walk the corner table, then random queries with
		// one full pause in the middle
		foreach (corner_tab[k])
			send_query(corner_tab[k].n, corner_tab[k].r, corner_tab[k].known,
				corner_tab[k].coef, corner_tab[k].oor);
		send_random(350, 1'b1);
		drain_results();

		// shrink the table first so later rebuilds stay short
		write_reg(bmpe_pkg::REG_TOP_INDEX, 31'd20);
		send_setting_corners();
		send_random(110, 1'b0);
		drain_results();

		// largest modulus
		write_reg(bmpe_pkg::REG_MODULUS, 31'h7FFF_FFFF);
		send_setting_corners();
		send_random(110, 1'b0);
		drain_results();

		// smallest prime
		write_reg(bmpe_pkg::REG_MODULUS, 31'd2);
		send_setting_corners();
		send_random(100, 1'b0);
		drain_results();

		// degenerate moduli: zero behaves as one, everything folds to 0
		write_reg(bmpe_pkg::REG_MODULUS, 31'd0);
		send_setting_corners();
		send_random(60, 1'b0);
		drain_results();
		write_reg(bmpe_pkg::REG_MODULUS, 31'd1);
		send_setting_corners();
		send_random(60, 1'b0);
		drain_results();

		// composite modulus on the smallest useful table, plus writes to
		// the spare slots, which must not touch the tables
		write_reg(bmpe_pkg::REG_MODULUS, 31'd15);
		write_reg(bmpe_pkg::REG_TOP_INDEX, 31'd1);
		write_reg(REG_SPARE_2, 31'($urandom()));
		write_reg(REG_SPARE_3, 31'($urandom()));
		send_setting_corners();
		send_random(100, 1'b0);
		drain_results();

		// table holding only entry 0
		write_reg(bmpe_pkg::REG_TOP_INDEX, 31'd0);
		write_reg(bmpe_pkg::REG_MODULUS, 31'd1000003);
		send_setting_corners();
		send_random(100, 1'b0);
		drain_results();

		write_reg(bmpe_pkg::REG_TOP_INDEX, 31'd63);
		write_reg(bmpe_pkg::REG_MODULUS, 31'd65537);
		send_setting_corners();
		send_random(120, 1'b0);
		drain_results();

		if (errors == 0 && coef_due_q.size() == 0) begin
			$display("tb_binomial_mod_prime_engine OK");
		end else begin
			$display("tb_binomial_mod_prime_engine NOT OK");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/bmpe_pkg.sv
rtl/bmpe_modmul.sv
rtl/bmpe_tables.sv
rtl/bmpe_builder.sv
rtl/binomial_mod_prime_engine.sv
tb/tb_binomial_mod_prime_engine.sv
